// File: hw/rtl/wrsg_pkg.sv
// Package for the windowed rate and slope gauge: sizes, opcodes and beat types.
`default_nettype none
package wrsg_pkg;

  // Ring depth and the widths that follow from it.
  localparam int MaxSamples = 1024;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CountW     = AddrW + 1;
  localparam int SumW       = 32 + CountW;

  // Largest held sample count for which a gauge is not run.
  localparam int MinGaugeCount = 10;

  // Opcodes.
  localparam logic [1:0] OpStore = 2'd0;
  localparam logic [1:0] OpGauge = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  // Signed 48-bit saturation limits.
  localparam logic [47:0] S48Max = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48Min = 48'h8000_0000_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sample_time;
    logic [31:0] sample_impulse;
    logic [31:0] query_time;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]        mean_time;
    logic signed [47:0] rate_value;
    logic signed [47:0] slope_value;
    logic               ready_flag;
    logic               span_error;
  } out_beat_t;

endpackage
`default_nettype wire

// File: hw/rtl/wrsg_ring.sv
// Sample ring: time and impulse stores with one write and one registered read port.
`default_nettype none
module wrsg_ring (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [wrsg_pkg::AddrW-1:0] waddr_i,
  input  wire logic [31:0]               wtime_i,
  input  wire logic [31:0]               wimpulse_i,
  input  wire logic [wrsg_pkg::AddrW-1:0] raddr_i,
  output logic      [31:0]               rtime_o,
  output logic      [31:0]               rimpulse_o
);
  import wrsg_pkg::*;

  logic [31:0] time_mem    [MaxSamples];
  logic [31:0] impulse_mem [MaxSamples];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i]    <= wtime_i;
      impulse_mem[waddr_i] <= wimpulse_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rtime_o    <= time_mem[raddr_i];
    rimpulse_o <= impulse_mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/wrsg_div.sv
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`default_nettype none
module wrsg_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic      [63:0] quotient_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic        done_q;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic        fits;

  // One restoring step on the partial remainder.
  always_comb begin
    shifted = {rem_q, dvd_q[63]};
    trial   = shifted - {1'b0, dsr_q};
    fits    = (shifted >= {1'b0, dsr_q});
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], fits};
      rem_q <= fits ? trial[31:0] : shifted[31:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
`default_nettype wire

// File: hw/rtl/windowed_rate_and_slope_gauge_unit.sv
// Top level of the windowed rate and slope gauge: sequencer, state and output register.
`default_nettype none
// A store beat writes the ring and leaves the sequencer idle. A gauge beat with
// more than ten samples walks the ring one entry a cycle and then runs up to
// three divisions on the shared divider (rate, mean time, slope). A query beat
// forms its low and high partial products on the shared 32x32 multiplier, sums
// them and emits. A gauge with too few samples goes straight to emit. The input
// is stalled while a gauge or query is in progress, and a result is held in
// the output register until taken. No clearing pass is needed after reset.
module windowed_rate_and_slope_gauge_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire wrsg_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output wrsg_pkg::out_beat_t       out_data_o
);
  import wrsg_pkg::*;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StWalk     = 4'd1;
  localparam logic [3:0] StDivRate  = 4'd2;
  localparam logic [3:0] StDivMean  = 4'd3;
  localparam logic [3:0] StDivSlope = 4'd4;
  localparam logic [3:0] StMulLo    = 4'd5;
  localparam logic [3:0] StMulHi    = 4'd6;
  localparam logic [3:0] StQSum     = 4'd7;
  localparam logic [3:0] StEmit     = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [AddrW-1:0]  wp_q;
  logic [CountW-1:0] count_q;
  logic [47:0]       cur_rate_q;
  logic [31:0]       cur_mean_q;
  logic [47:0]       cur_slope_q;
  logic              ready_q;
  logic              out_valid_q;
  out_beat_t         out_q;

  logic [CountW-1:0] idx_q;
  logic              rd_pend_q;
  logic [31:0]       tmin_q, tmax_q;
  logic [SumW-1:0]   tsum_q, ysum_q;
  logic [47:0]       nrate_q;
  logic              sneg_q;
  logic [47:0]       res_rate_q;
  logic              res_err_q;
  logic [31:0]       qtime_q;
  logic [63:0]       prod_lo_q, prod_hi_q;

  logic              accept;
  logic              out_free;
  logic              walk_done;
  logic [31:0]       rd_time, rd_imp;
  logic              div_start;
  logic [63:0]       div_dividend;
  logic [31:0]       div_divisor;
  logic              div_done;
  logic [63:0]       div_q;
  logic [31:0]       span;
  logic [47:0]       rate_sat;
  logic [31:0]       mean_new;
  logic              tneg;
  logic [31:0]       tmag;
  logic [48:0]       drate;
  logic              rneg;
  logic [47:0]       dmag_r;
  logic [47:0]       slope_sat;
  logic              dneg;
  logic [31:0]       dmag_q;
  logic              slneg;
  logic [47:0]       smag;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       term;
  logic [48:0]       tcap;
  logic [50:0]       tsig;
  logic [50:0]       qsum;
  logic [47:0]       qrate;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  // Sample ring.
  wrsg_ring u_ring (
    .clk_i     (clk_i),
    .we_i      (accept && (in_data_i.opcode == OpStore)),
    .waddr_i   (wp_q),
    .wtime_i   (in_data_i.sample_time),
    .wimpulse_i(in_data_i.sample_impulse),
    .raddr_i   (idx_q[AddrW-1:0]),
    .rtime_o   (rd_time),
    .rimpulse_o(rd_imp)
  );

  // Shared divider.
  wrsg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  // Gauge arithmetic around the divider.
  always_comb begin
    walk_done = (idx_q == count_q) && !rd_pend_q;
    span      = tmax_q - tmin_q;
    rate_sat  = (div_q > {16'd0, S48Max}) ? S48Max : div_q[47:0];
    mean_new  = div_q[31:0];
    tneg      = mean_new < cur_mean_q;
    tmag      = tneg ? (cur_mean_q - mean_new) : (mean_new - cur_mean_q);
    drate     = {nrate_q[47], nrate_q} - {cur_rate_q[47], cur_rate_q};
    rneg      = drate[48];
    dmag_r    = rneg ? 48'(-drate) : drate[47:0];
    if (sneg_q) begin
      slope_sat = (div_q >= {16'd0, S48Min}) ? S48Min : 48'(-div_q);
    end else begin
      slope_sat = (div_q > {16'd0, S48Max}) ? S48Max : div_q[47:0];
    end

    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      StWalk: begin
        div_start    = walk_done && (span != 32'd0);
        div_dividend = 64'({ysum_q, 16'd0});
        div_divisor  = span;
      end
      StDivRate: begin
        div_start    = div_done;
        div_dividend = 64'(tsum_q);
        div_divisor  = 32'(count_q);
      end
      StDivMean: begin
        div_start    = div_done && (mean_new != cur_mean_q);
        div_dividend = {dmag_r, 16'd0};
        div_divisor  = tmag;
      end
      default: begin
      end
    endcase
  end

  // Query arithmetic on the shared multiplier.
  always_comb begin
    dneg   = qtime_q < cur_mean_q;
    dmag_q = dneg ? (cur_mean_q - qtime_q) : (qtime_q - cur_mean_q);
    slneg  = cur_slope_q[47];
    smag   = slneg ? (-cur_slope_q) : cur_slope_q;
    mul_b  = (state_q == StMulLo) ? {16'd0, smag[15:0]} : smag[47:16];
    mul_p  = 64'(dmag_q) * 64'(mul_b);
    term   = prod_hi_q + {16'd0, prod_lo_q[63:16]};
    tcap   = (term > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : term[48:0];
    tsig   = (dneg != slneg) ? (51'd0 - {2'b00, tcap}) : {2'b00, tcap};
    qsum   = {{3{cur_rate_q[47]}}, cur_rate_q} + tsig;
    if (!qsum[50] && (qsum[49:47] != 3'b000)) begin
      qrate = S48Max;
    end else if (qsum[50] && (qsum[49:47] != 3'b111)) begin
      qrate = S48Min;
    end else begin
      qrate = qsum[47:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_data_i.opcode == OpGauge) begin
            state_d = (count_q > CountW'(MinGaugeCount)) ? StWalk : StEmit;
          end else if (in_data_i.opcode == OpQuery) begin
            state_d = StMulLo;
          end
        end
      end
      StWalk: begin
        if (walk_done) state_d = (span != 32'd0) ? StDivRate : StEmit;
      end
      StDivRate: begin
        if (div_done) state_d = StDivMean;
      end
      StDivMean: begin
        if (div_done) state_d = (mean_new != cur_mean_q) ? StDivSlope : StEmit;
      end
      StDivSlope: begin
        if (div_done) state_d = StEmit;
      end
      StMulLo: state_d = StMulHi;
      StMulHi: state_d = StQSum;
      StQSum:  state_d = StEmit;
      StEmit: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      count_q     <= '0;
      cur_rate_q  <= '0;
      cur_mean_q  <= '0;
      cur_slope_q <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      // A store beat writes the ring and advances the pointer.
      if (accept && (in_data_i.opcode == OpStore)) begin
        wp_q <= wp_q + AddrW'(1);
        if (count_q != CountW'(MaxSamples)) count_q <= count_q + CountW'(1);
      end

      // Ring walk read addressing.
      if (state_q == StIdle) begin
        idx_q     <= '0;
        rd_pend_q <= 1'b0;
      end else if (state_q == StWalk) begin
        rd_pend_q <= (idx_q != count_q);
        if (idx_q != count_q) idx_q <= idx_q + CountW'(1);
      end

      // Commit of a successful gauge.
      if ((state_q == StDivMean) && div_done) begin
        cur_rate_q <= nrate_q;
        cur_mean_q <= mean_new;
        ready_q    <= 1'b1;
        count_q    <= '0;
        wp_q       <= '0;
      end
      if ((state_q == StDivSlope) && div_done) cur_slope_q <= slope_sat;

      if ((state_q == StEmit) && out_free) out_valid_q <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qtime_q    <= in_data_i.query_time;
      res_rate_q <= cur_rate_q;
      res_err_q  <= 1'b0;
    end
    if ((state_q == StIdle) || (state_q == StEmit)) begin
      tmin_q <= 32'hFFFF_FFFF;
      tmax_q <= '0;
      tsum_q <= '0;
      ysum_q <= '0;
    end else if ((state_q == StWalk) && rd_pend_q) begin
      if (rd_time < tmin_q) tmin_q <= rd_time;
      if (rd_time > tmax_q) tmax_q <= rd_time;
      tsum_q <= tsum_q + SumW'(rd_time);
      ysum_q <= ysum_q + SumW'(rd_imp);
    end
    if ((state_q == StWalk) && walk_done && (span == 32'd0)) res_err_q <= 1'b1;
    if ((state_q == StDivRate) && div_done) nrate_q <= rate_sat;
    if ((state_q == StDivMean) && div_done) begin
      sneg_q     <= rneg != tneg;
      res_rate_q <= nrate_q;
    end
    if (state_q == StMulLo) prod_lo_q <= mul_p;
    if (state_q == StMulHi) prod_hi_q <= mul_p;
    if (state_q == StQSum) res_rate_q <= qrate;
    if ((state_q == StEmit) && out_free) begin
      out_q.mean_time   <= cur_mean_q;
      out_q.rate_value  <= res_rate_q;
      out_q.slope_value <= cur_slope_q;
      out_q.ready_flag  <= ready_q;
      out_q.span_error  <= res_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: tb/windowed_rate_and_slope_gauge_unit_test.sv
// Testbench for the windowed rate and slope gauge: directed and random beats against a predictor.
`timescale 1ns / 1ps
module windowed_rate_and_slope_gauge_unit_test;
  import wrsg_pkg::*;

  localparam logic [1:0] OpIdle = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_data_o;

  windowed_rate_and_slope_gauge_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // Predicted state of the gauge.
  logic [31:0] ring_time [MaxSamples];
  logic [31:0] ring_impulse [MaxSamples];
  int unsigned ring_wr;
  int unsigned ring_fill;
  logic signed [47:0] gauge_rate;
  logic [31:0] gauge_mean;
  logic signed [47:0] gauge_slope;
  logic gauge_ready;

  out_beat_t pending_results[$];
  int error_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  initial forever #1 clk_i = ~clk_i;

  // Sign a magnitude and clamp it to 48 bits.
  function automatic logic signed [47:0] clamp_signed(logic [63:0] mag, bit neg);
    if (neg) return (mag >= 64'h8000_0000_0000) ? $signed(S48Min) : -$signed(mag[47:0]);
    return (mag > 64'h7FFF_FFFF_FFFF) ? $signed(S48Max) : $signed(mag[47:0]);
  endfunction

  function automatic out_beat_t form_result(logic signed [47:0] rate, bit err);
    out_beat_t r;
    r.mean_time = gauge_mean;
    r.rate_value = rate;
    r.slope_value = gauge_slope;
    r.ready_flag = gauge_ready;
    r.span_error = err;
    return r;
  endfunction

  // Queue one predicted result at the back.
  function automatic void enqueue_result(out_beat_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Walk the held samples; returns 0 when the time span is zero.
  function automatic bit fold_window();
    logic [31:0] tmin, tmax, new_mean, tmag;
    logic [63:0] tsum, ysum, span, rmag, dmag;
    logic signed [63:0] drate;
    logic signed [47:0] new_rate;
    bit tneg, rneg;
    tmin = '1;
    tmax = '0;
    tsum = '0;
    ysum = '0;
    for (int i = 0; i < ring_fill; i++) begin
      if (ring_time[i] < tmin) tmin = ring_time[i];
      if (ring_time[i] > tmax) tmax = ring_time[i];
      tsum += ring_time[i];
      ysum += ring_impulse[i];
    end
    span = tmax - tmin;
    if (span == 0) return 1'b0;
    rmag = (ysum << 16) / span;
    new_rate = clamp_signed(rmag, 1'b0);
    new_mean = 32'(tsum / ring_fill);
    if (new_mean != gauge_mean) begin
      tneg = new_mean < gauge_mean;
      tmag = tneg ? gauge_mean - new_mean : new_mean - gauge_mean;
      drate = 64'(new_rate) - 64'(gauge_rate);
      rneg = drate < 0;
      dmag = rneg ? 64'(-drate) : 64'(drate);
      gauge_slope = clamp_signed((dmag << 16) / tmag, rneg != tneg);
    end
    gauge_rate = new_rate;
    gauge_mean = new_mean;
    gauge_ready = 1'b1;
    ring_fill = 0;
    ring_wr = 0;
    return 1'b1;
  endfunction

  function automatic logic signed [47:0] extrapolated_rate(logic [31:0] q);
    logic [63:0] dmag, smag, term;
    logic signed [63:0] t, s;
    bit dneg, sneg;
    dneg = q < gauge_mean;
    dmag = dneg ? 64'(gauge_mean - q) : 64'(q - gauge_mean);
    sneg = gauge_slope < 0;
    smag = sneg ? 64'(-64'(gauge_slope)) : 64'(gauge_slope);
    term = dmag * (smag >> 16) + ((dmag * (smag & 64'hFFFF)) >> 16);
    if (term > (64'd1 << 48)) term = 64'd1 << 48;
    t = dneg != sneg ? -$signed(term) : $signed(term);
    s = 64'(gauge_rate) + t;
    if (s > $signed(64'h7FFF_FFFF_FFFF)) return $signed(S48Max);
    if (s < -$signed(64'h8000_0000_0000)) return $signed(S48Min);
    return s[47:0];
  endfunction

  // Update the predicted state for one accepted beat.
  function automatic void predict_beat(in_beat_t b);
    bit err;
    case (b.opcode)
      OpStore: begin
        ring_time[ring_wr] = b.sample_time;
        ring_impulse[ring_wr] = b.sample_impulse;
        ring_wr = (ring_wr + 1) % MaxSamples;
        if (ring_fill < MaxSamples) ring_fill++;
      end
      OpGauge: begin
        err = 1'b0;
        if (ring_fill > MinGaugeCount) err = !fold_window();
        enqueue_result(form_result(gauge_rate, err));
      end
      OpQuery: enqueue_result(form_result(extrapolated_rate(b.query_time), 1'b0));
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Send one beat, holding it until accepted; valid stays high for a following beat.
  task automatic send_beat(in_beat_t b);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_beat(b);
  endtask

  function automatic in_beat_t make_beat(logic [1:0] op, logic [31:0] t, logic [31:0] y,
                                         logic [31:0] q);
    in_beat_t b;
    b.opcode = op;
    b.sample_time = t;
    b.sample_impulse = y;
    b.query_time = q;
    return b;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver stall and result checking.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data_o.mean_time), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.mean_time !== want.mean_time)
          report_mismatch("mean_time", 64'(out_data_o.mean_time), 64'(want.mean_time));
        if (out_data_o.rate_value !== want.rate_value)
          report_mismatch("rate_value", 64'(out_data_o.rate_value), 64'(want.rate_value));
        if (out_data_o.slope_value !== want.slope_value)
          report_mismatch("slope_value", 64'(out_data_o.slope_value), 64'(want.slope_value));
        if (out_data_o.ready_flag !== want.ready_flag)
          report_mismatch("ready_flag", 64'(out_data_o.ready_flag), 64'(want.ready_flag));
        if (out_data_o.span_error !== want.span_error)
          report_mismatch("span_error", 64'(out_data_o.span_error), 64'(want.span_error));
      end
    end
    out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Queries before any gauge, a too-small gauge, the extremes and an unused opcode.
  task automatic test_directed_edges();
    send_beat(make_beat(OpQuery, '1, '1, '1));
    send_beat(make_beat(OpIdle, '1, '1, '1));
    repeat (10) send_beat(make_beat(OpStore, '1, '1, '0));
    send_beat(make_beat(OpGauge, '0, '0, '0));
    send_beat(make_beat(OpStore, '1, '1, '0));
    // Eleven samples of one time: zero span keeps everything.
    send_beat(make_beat(OpGauge, '0, '0, '0));
    send_beat(make_beat(OpStore, '0, '1, '0));
    send_beat(make_beat(OpGauge, '0, '0, '0));
    send_beat(make_beat(OpQuery, '0, '0, '0));
    send_beat(make_beat(OpQuery, '1, '0, '1));
  endtask

  // A window whose mean equals the previous one keeps the old slope.
  task automatic test_equal_mean();
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 12; i++)
        send_beat(make_beat(OpStore, 32'h0001_0000 * i, 32'h0400_0000 >> r, '0));
      send_beat(make_beat(OpGauge, '0, '0, '0));
    end
    send_beat(make_beat(OpQuery, '0, '0, 32'h8000_0000));
  endtask

  // Random windows of stores, then a gauge and queries, with some noise.
  task automatic test_random_windows(int beats);
    int sent, n, base, pick;
    logic [31:0] t;
    sent = 0;
    while (sent < beats) begin
      n = $urandom_range(40, 5);
      base = $urandom;
      pick = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        t = pick == 0 ? $urandom : base + $urandom_range(pick == 1 ? 32'hFF : 32'hFFFFF);
        send_beat(make_beat(OpStore, t, pick == 2 ? $urandom_range(255) : $urandom, $urandom));
      end
      send_beat(make_beat(OpGauge, $urandom, $urandom, $urandom));
      repeat ($urandom_range(2)) send_beat(make_beat(OpQuery, $urandom, $urandom, $urandom));
      if ($urandom_range(9) == 0) send_beat(make_beat(OpIdle, $urandom, $urandom, $urandom));
      sent += n + 2;
    end
  endtask

  initial begin
    ring_wr = 0;
    ring_fill = 0;
    gauge_rate = '0;
    gauge_mean = '0;
    gauge_slope = '0;
    gauge_ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_equal_mean();
    test_random_windows(110);
    send_gap_pct = 58;
    test_random_windows(110);
    send_gap_pct = 0;
    recv_stall_pct = 58;
    test_random_windows(110);
    send_gap_pct = 20;
    recv_stall_pct = 20;
    test_random_windows(110);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (error_count == 0) $display("PASS windowed_rate_and_slope_gauge_unit");
    else $display("FAIL windowed_rate_and_slope_gauge_unit");
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("FAIL windowed_rate_and_slope_gauge_unit");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/wrsg_pkg.sv
hw/rtl/wrsg_ring.sv
hw/rtl/wrsg_div.sv
hw/rtl/windowed_rate_and_slope_gauge_unit.sv
tb/windowed_rate_and_slope_gauge_unit_test.sv
